// ===== sv/direct_mapped_transposition_table_top_assert.svh =====
// Assertion helpers used by the checker file dmtt_checker.sv.
`ifndef DIRECT_MAPPED_TRANSPOSITION_TABLE_TOP_ASSERT_SVH
`define DIRECT_MAPPED_TRANSPOSITION_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define DMTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define DMTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dmtt_pkg.sv =====
`default_nettype none

package dmtt_pkg;

   // Table geometry
   localparam int INDEX_BITS  = 12;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BITS_USED = 2'd1;
   localparam logic                   TABLE_ENABLE_RESET    = 1'b1;
   localparam logic [3:0]             INDEX_BITS_USED_RESET = 4'd12;

   // Item codes
   localparam logic       OP_PROBE   = 1'b0;
   localparam logic       OP_STORE   = 1'b1;
   localparam logic [1:0] KIND_EXACT = 2'd0;
   localparam logic [1:0] KIND_LOWER = 2'd1;

   typedef struct packed {
      logic               opcode;
      logic [63:0]        position_hash;
      logic signed [15:0] bound_beta;
      logic signed [15:0] store_score;
      logic [1:0]         node_kind;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] found_score;
   } rsp_type;

   // One table word
   typedef struct packed {
      logic        valid;
      logic [63:0] tag;
      logic [15:0] score;
      logic [1:0]  kind;
   } entry_type;

   // Entry index: hash low bits, limited to the bits in use
   function automatic logic [INDEX_BITS-1:0] slot_of(input logic [63:0] hash,
                                                     input logic [3:0]  bits_used);
      logic [INDEX_BITS-1:0] mask;
      mask = '0;
      for (int i = 0; i < INDEX_BITS; i++) begin
         mask[i] = (i < int'(bits_used));
      end
      return hash[INDEX_BITS-1:0] & mask;
   endfunction

endpackage

`default_nettype wire

// ===== sv/direct_mapped_transposition_table_top.sv =====
// Direct-mapped transposition table, always-replace. An item is accepted on a
// clock edge with start high and busy low, one item per cycle at full rate;
// its result shows on rsp_item with rsp_valid high for exactly one cycle, after
// the s1 and rsp registers, in order (store results carry hit 0, score 0). The
// receiver cannot stall. The table lives in one synchronous memory with one
// read port and one write port; a store writes it on the accepting edge and a
// probe reads it on the accepting edge, so neighboring items never collide.
// After reset and after each write to register 0 or 1, busy stays high for a
// clearing pass over all 2^INDEX_BITS (4096) entries that zeroes every valid
// mark; a register write during the pass restarts it. The user must write the
// csr_* registers only while no item is in flight; the block does not enforce it.
`default_nettype none

module direct_mapped_transposition_table_top
   import dmtt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration and clearing state
   logic                  table_enable_ff, table_enable_in;
   logic [3:0]            index_bits_used_ff, index_bits_used_in;
   logic                  clr_active_ff, clr_active_in;
   logic [INDEX_BITS-1:0] clr_idx_ff, clr_idx_in;

   // Pipeline state
   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_item_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_item_ff, rsp_item_in;

   // Memory
   entry_type             mem [TABLE_DEPTH];
   entry_type             rd_data_ff;
   logic                  mem_we;
   logic [INDEX_BITS-1:0] mem_waddr;
   entry_type             mem_wdata;
   logic [INDEX_BITS-1:0] slot;
   logic                  accept;
   logic                  csr_hit;

   assign accept  = start && !clr_active_ff;
   assign busy    = clr_active_ff;
   assign slot    = slot_of(req_item.position_hash, index_bits_used_ff);
   assign csr_hit = csr_write_en &&
                    (csr_index == CSR_TABLE_ENABLE || csr_index == CSR_INDEX_BITS_USED);

   // Register writes and the clearing pass
   always_comb begin
      table_enable_in    = table_enable_ff;
      index_bits_used_in = index_bits_used_ff;
      clr_active_in      = clr_active_ff;
      clr_idx_in         = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + INDEX_BITS'(1);
         if (clr_idx_ff == {INDEX_BITS{1'b1}}) begin
            clr_active_in = 1'b0;
         end
      end
      if (csr_write_en) begin
         case (csr_index)
            CSR_TABLE_ENABLE:    table_enable_in    = csr_wdata[0];
            CSR_INDEX_BITS_USED: index_bits_used_in = csr_wdata[3:0];
            default:             ;
         endcase
      end
      if (csr_hit) begin
         clr_active_in = 1'b1;
         clr_idx_in    = '0;
      end
   end

   // Memory write: clearing pass or an accepted store
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot;
      mem_wdata.valid = 1'b1;
      mem_wdata.tag   = req_item.position_hash;
      mem_wdata.score = req_item.store_score;
      mem_wdata.kind  = req_item.node_kind;
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else if (accept && req_item.opcode == OP_STORE && table_enable_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[slot];
   end

   // Hit check on the read data
   always_comb begin
      s1_valid_in  = accept;
      rsp_valid_in = s1_valid_ff;
      rsp_item_in  = '0;
      if (s1_valid_ff && table_enable_ff && s1_item_ff.opcode == OP_PROBE &&
          rd_data_ff.valid && rd_data_ff.tag == s1_item_ff.position_hash) begin
         if (rd_data_ff.kind == KIND_EXACT ||
             (rd_data_ff.kind == KIND_LOWER &&
              $signed(rd_data_ff.score) >= s1_item_ff.bound_beta)) begin
            rsp_item_in.hit         = 1'b1;
            rsp_item_in.found_score = rd_data_ff.score;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_enable_ff    <= TABLE_ENABLE_RESET;
         index_bits_used_ff <= INDEX_BITS_USED_RESET;
         clr_active_ff      <= 1'b1;
         clr_idx_ff         <= '0;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         table_enable_ff    <= table_enable_in;
         index_bits_used_ff <= index_bits_used_in;
         clr_active_ff      <= clr_active_in;
         clr_idx_ff         <= clr_idx_in;
         s1_valid_ff        <= s1_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_item_ff  <= req_item;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== sv/dmtt_checker.sv =====
`default_nettype none
`include "direct_mapped_transposition_table_top_assert.svh"

module dmtt_checker
   import dmtt_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire req_type                req_item,
   input wire logic                   rsp_valid,
   input wire rsp_type                rsp_item,
   input wire logic                   csr_write_en,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic accept_q1_ff;
   logic accept_q2_ff;
   logic store_q1_ff;
   logic store_q2_ff;
   logic csr_seen;

   assign csr_seen = csr_write_en && csr_wdata == csr_wdata &&
                     (csr_index == CSR_TABLE_ENABLE || csr_index == CSR_INDEX_BITS_USED);

   // Track accepted transfers and stores through the q1 and q2 delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accept_q1_ff <= 1'b0;
         accept_q2_ff <= 1'b0;
         store_q1_ff  <= 1'b0;
         store_q2_ff  <= 1'b0;
      end else begin
         accept_q1_ff <= start && !busy;
         accept_q2_ff <= accept_q1_ff;
         store_q1_ff  <= start && !busy && req_item.opcode == OP_STORE;
         store_q2_ff  <= store_q1_ff;
      end
   end

   // Exactly one result per accepted item, matched against accept_q2_ff
   `DMTT_ASSERT_NOW(a_rsp_matches_accept, clock, reset, 1'b1, rsp_valid == accept_q2_ff, "result does not match accepted transfer")

   // A store never reports a hit
   `DMTT_ASSERT_NOW(a_store_no_hit, clock, reset, rsp_valid && store_q2_ff, !rsp_item.hit, "store reported a hit")

   // A miss carries a zero score
   `DMTT_ASSERT_NOW(a_miss_zero_score, clock, reset, rsp_valid && !rsp_item.hit, rsp_item.found_score == 16'sd0, "miss with nonzero score")

   // A register write starts the clearing pass
   `DMTT_ASSERT_NEXT(a_csr_clears, clock, reset, csr_seen, busy, "register write did not start clearing")

endmodule

bind direct_mapped_transposition_table_top dmtt_checker u_dmtt_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_item     (req_item),
   .rsp_valid    (rsp_valid),
   .rsp_item     (rsp_item),
   .csr_write_en (csr_write_en),
   .csr_index    (csr_index),
   .csr_wdata    (csr_wdata)
);

`default_nettype wire
